// ===== hdl/aes256_kx_pkg.sv =====
// Shared types, constants and table functions for the AES-256 key expansion block.
`default_nettype none
package aes256_kx_pkg;

  localparam int unsigned RoundKeys = 15;
  localparam int unsigned RoundW = 4;
  localparam int unsigned WordW = 32;
  localparam int unsigned KeyW = 64;

  typedef struct packed {
    logic load;
    logic step;
  } kx_cmd_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] s [256];
    s = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return s[a];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // Round constant for the step that yields round key 2r (r from 1).
  function automatic logic [7:0] rcon(input logic [2:0] r);
    logic [7:0] v;
    case (r)
      3'd1: v = 8'h01;
      3'd2: v = 8'h02;
      3'd3: v = 8'h04;
      3'd4: v = 8'h08;
      3'd5: v = 8'h10;
      3'd6: v = 8'h20;
      3'd7: v = 8'h40;
      default: v = 8'h8d;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/aes256_key_expansion_core.sv =====
// AES-256 key expansion: top level joining sequencer and schedule datapath.
// Usage:
//  A key request is taken on in_valid/in_ready as four 64-bit parts.
//  The block then offers 15 round keys on out_valid/out_ready, round 0 first,
//  final_round_key high on round 14. Round 0 appears the cycle after the
//  request is taken; each further round key follows in the cycle after the
//  previous one is taken.
//  One schedule step (one four-word advance with four S-box lookups) runs
//  as each round key but the last is taken, from an eight-word window register.
//  in_ready is high only while no key is in progress.
//  If the receiver stalls, the current round key is held unchanged.
//  Reset (rst, synchronous) returns to idle; any key in progress is dropped.
`default_nettype none
module aes256_key_expansion_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] key_part_a,
  input  wire logic [63:0] key_part_b,
  input  wire logic [63:0] key_part_c,
  input  wire logic [63:0] key_part_d,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       round_number,
  output logic [63:0]      round_key_upper,
  output logic [63:0]      round_key_lower,
  output logic             final_round_key
);
  import aes256_kx_pkg::*;

  kx_cmd_t    cmd;
  logic [3:0] round;

  aes256_kx_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd),
    .round(round), .last(final_round_key)
  );

  aes256_kx_datapath u_dp (
    .clk(clk), .cmd(cmd), .key_part_a(key_part_a), .key_part_b(key_part_b),
    .key_part_c(key_part_c), .key_part_d(key_part_d), .round(round),
    .key_upper(round_key_upper), .key_lower(round_key_lower)
  );

  assign round_number = round;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("request taken mid-run");
  a_round_adv: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !final_round_key |=> out_valid &&
    round_number == $past(round_number) + 4'd1) else $error("round skipped");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && final_round_key |=> in_ready)
    else $error("no idle after last key");
endmodule
`default_nettype wire

// ===== hdl/aes256_kx_datapath.sv =====
// Key schedule window: eight words, advanced by four words per step.
`default_nettype none
module aes256_kx_datapath (
  input  wire logic                  clk,
  input  wire aes256_kx_pkg::kx_cmd_t cmd,
  input  wire logic [63:0]           key_part_a,
  input  wire logic [63:0]           key_part_b,
  input  wire logic [63:0]           key_part_c,
  input  wire logic [63:0]           key_part_d,
  input  wire logic [3:0]            round,
  output logic      [63:0]           key_upper,
  output logic      [63:0]           key_lower
);
  import aes256_kx_pkg::*;

  // win holds words 4r .. 4r+7, word 4r in the top position
  logic [255:0] win;
  logic [255:0] win_next;
  logic [31:0]  t;
  logic [31:0]  n0, n1, n2, n3;

  // Odd r: new words start at index 4r+8 with i mod 8 == 4; even: i mod 8 == 0
  always_comb begin
    if (round[0]) begin
      t = sub_word(win[31:0]);
    end else begin
      t = sub_word({win[23:0], win[31:24]}) ^ {rcon(round[3:1] + 3'd1), 24'h0};
    end
    n0 = win[255:224] ^ t;
    n1 = win[223:192] ^ n0;
    n2 = win[191:160] ^ n1;
    n3 = win[159:128] ^ n2;
    win_next = {win[127:0], n0, n1, n2, n3};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      win <= {key_part_a, key_part_b, key_part_c, key_part_d};
    end else if (cmd.step) begin
      win <= win_next;
    end
  end

  assign key_upper = win[255:192];
  assign key_lower = win[191:128];
endmodule
`default_nettype wire

// ===== hdl/aes256_kx_ctrl.sv =====
// Sequencer: takes a key request, then hands out fifteen round keys.
`default_nettype none
module aes256_kx_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output aes256_kx_pkg::kx_cmd_t      cmd,
  output logic [3:0]                  round,
  output logic                        last
);
  import aes256_kx_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic [RoundW-1:0] round_next;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_RUN);
  assign last      = (round == RoundW'(RoundKeys - 1));
  assign cmd.load  = in_valid && in_ready;
  assign cmd.step  = out_valid && out_ready && !last;
  assign round_next = round + RoundW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      round <= '0;
    end else begin
      case (state)
        ST_IDLE: if (cmd.load) begin
          state <= ST_RUN;
          round <= '0;
        end
        ST_RUN: if (out_ready) begin
          if (last) begin
            state <= ST_IDLE;
          end else begin
            round <= round_next;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
